// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define STPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define STPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/stpc_pkg.sv
// ----------------------------------------------------------------------------
// stpc_pkg
// Types and fixed constants of the steer-to-target PI controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stpc_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_ZONE     = 11'b000_0000_0010,
    S_DIV_INC  = 11'b000_0000_0100,
    S_INT_UPD  = 11'b000_0000_1000,
    S_TURN_ADD = 11'b000_0001_0000,
    S_TURN_LD  = 11'b000_0010_0000,
    S_DIV_TURN = 11'b000_0100_0000,
    S_TURN_SAT = 11'b000_1000_0000,
    S_MUL_LD   = 11'b001_0000_0000,
    S_MUL_RUN  = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  // Products formed in turn by the serial multiplier.
  typedef enum logic [2:0] {
    OP_SQUARE   = 3'd0,
    OP_CUBE     = 3'd1,
    OP_LINEAR   = 3'd2,
    OP_CUBIC    = 3'd3,
    OP_THROTTLE = 3'd4
  } mul_op_t;

  // Configuration register indexes.
  localparam logic [0:0] REG_LINEAR_WEIGHT = 1'd0;
  localparam logic [0:0] REG_CUBIC_WEIGHT  = 1'd1;
  localparam logic [15:0] WEIGHT_RESET     = 16'd16384;

  // Datapath widths.
  localparam int ERR_W   = 18;  // selected error, up to +65536
  localparam int INTEG_W = 22;  // integral, clamped to +-0.1 in Q24
  localparam int DIV_W   = 27;  // divider dividend and quotient
  localparam int REM_W   = 14;  // divider remainder and divisor
  localparam int TURN_W  = 35;  // turn numerator, integral*100 + error*196608
  localparam int MULA_W  = 33;  // multiplicand
  localparam int MULB_W  = 16;  // multiplier, consumed one bit per cycle
  localparam int ACC_W   = MULA_W + MULB_W;

  // Iteration counts, stored as the last count value.
  localparam logic [4:0] DIV_STEPS_LAST  = 5'd26;
  localparam logic [4:0] MUL_STEPS_LAST  = 5'd15;
  localparam logic [4:0] TURN_TERMS_LAST = 5'd4;

  // Error selection.
  localparam logic [3:0]         TRACK_MODE    = 4'd4;
  localparam logic signed [16:0] HEADING_LIMIT = 17'sd2560;

  // Integral zones, in 1/256 degree, and their dividers with half for rounding.
  localparam logic [ERR_W-1:0] FINE_ZONE      = 18'd128;
  localparam logic [ERR_W-1:0] COARSE_ZONE    = 18'd1280;
  localparam logic [REM_W-1:0] FINE_DIVISOR   = 14'd1000;
  localparam logic [15:0]      FINE_HALF      = 16'd500;
  localparam logic [REM_W-1:0] COARSE_DIVISOR = 14'd10000;
  localparam logic [15:0]      COARSE_HALF    = 16'd5000;

  localparam logic signed [INTEG_W:0] INTEGRAL_LIMIT = 23'sd1677722;

  // Turn: numerator / (512 * 100), the 512 taken by a shift.
  localparam logic [REM_W-1:0]         TURN_DIVISOR   = 14'd100;
  localparam logic signed [TURN_W-1:0] TURN_HALF      = 35'sd25600;
  localparam logic [13:0]              TURN_LIMIT_MAG = 14'd9830;

  localparam logic [15:0] DRIVE_LIMIT_MAG = 16'd32767;

endpackage

// File: sv/steer_to_target_pi_control.sv
// ----------------------------------------------------------------------------
// steer_to_target_pi_control
// PI steering controller with integral zones and a shaped, throttled drive.
// ----------------------------------------------------------------------------
// Each input transaction is one control tick. The block picks a steering error
// from the camera and the gyro, updates a two-zone integral, and returns one
// output transaction with a turn command (integral + 0.03 * error, clamped to
// +-0.3) and a drive command (linear plus cubic joystick curve times throttle,
// saturated). It handles one tick at a time and is ready again only once the
// tick is finished; when the error is 5 degrees or more the integral is reset
// and the increment division is skipped. The work is two bit-serial divisions
// (integral increment, turn scaling) and five bit-serial multiplications on
// the drive path, all sequenced through one divider and one multiplier. The
// result sits in an output register, so the next tick can be accepted while
// the previous result waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module steer_to_target_pi_control (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [13:0] target_angle,
  input  logic               target_seen,
  input  logic [3:0]         camera_mode,
  input  logic signed [16:0] heading,
  input  logic signed [15:0] stick_y,
  input  logic [15:0]        throttle_level,
  // Output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] drive_speed,
  output logic signed [14:0] turn_rate
);

  localparam int ERR_W   = stpc_pkg::ERR_W;
  localparam int INTEG_W = stpc_pkg::INTEG_W;
  localparam int DIV_W   = stpc_pkg::DIV_W;
  localparam int REM_W   = stpc_pkg::REM_W;
  localparam int TURN_W  = stpc_pkg::TURN_W;
  localparam int MULA_W  = stpc_pkg::MULA_W;
  localparam int MULB_W  = stpc_pkg::MULB_W;
  localparam int ACC_W   = stpc_pkg::ACC_W;

  // Sequencer and shared iteration counter.
  stpc_pkg::state_t  state;
  stpc_pkg::mul_op_t mul_op;
  stpc_pkg::mul_op_t mul_op_next;
  logic [4:0]        cnt;

  // Configuration registers.
  logic [15:0] lin_weight;
  logic [15:0] cub_weight;

  // Values captured from the accepted tick.
  logic signed [ERR_W-1:0] err;
  logic [15:0]             stick_mag;
  logic                    stick_neg;
  logic [15:0]             thr;

  // Integral state.
  logic signed [INTEG_W-1:0] integ;

  // Bit-serial restoring divider.
  logic [DIV_W-1:0] dq;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] divisor;

  // Turn path.
  logic signed [TURN_W-1:0] tacc;
  logic                     tneg;
  logic signed [14:0]       turn_val;

  // Bit-serial shift-add multiplier.
  logic [MULA_W-1:0] mul_a;
  logic [MULB_W-1:0] mul_b;
  logic [ACC_W-1:0]  acc;
  logic [15:0]       cube_mag;
  logic [31:0]       mix_lin;

  // --------------------------------------------------------------------------
  // Error selection at acceptance. Camera tracking mode wins, then a large
  // heading steers back, then a seen target, otherwise no error.
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0] angle_ext;
  logic signed [ERR_W-1:0] head_ext;
  logic signed [ERR_W-1:0] err_sel;
  logic                    head_big;
  logic signed [16:0]      stick_ext;
  logic signed [16:0]      stick_abs;

  always_comb begin
    angle_ext = {{(ERR_W-14){target_angle[13]}}, target_angle};
    head_ext  = {{(ERR_W-17){heading[16]}}, heading};
    head_big  = (heading >= stpc_pkg::HEADING_LIMIT) ||
                (heading <= -stpc_pkg::HEADING_LIMIT);
    if (camera_mode == stpc_pkg::TRACK_MODE) begin
      err_sel = angle_ext;
    end else if (head_big) begin
      err_sel = -head_ext;
    end else if (target_seen) begin
      err_sel = angle_ext;
    end else begin
      err_sel = '0;
    end
    stick_ext = {stick_y[15], stick_y};
    stick_abs = stick_y[15] ? -stick_ext : stick_ext;
  end

  // --------------------------------------------------------------------------
  // Per-state datapath helpers.
  // --------------------------------------------------------------------------
  logic [ERR_W-1:0]          err_mag;
  logic [REM_W:0]            rem_sh;
  logic                      rem_ge;
  logic [REM_W:0]            rem_diff;
  logic [REM_W-1:0]          rem_next;
  logic signed [INTEG_W:0]   inc_ext;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [TURN_W-1:0]  term;
  logic signed [TURN_W-1:0]  tmag;
  logic [13:0]               tq;
  logic [MULA_W:0]           mul_sum;
  logic [ACC_W-1:0]          acc_step;
  logic [18:0]               acc_round;
  logic [15:0]               drive_mag;
  logic signed [15:0]        drive_val;

  always_comb begin
    err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    // One quotient bit per cycle.
    rem_sh   = {rem, dq[DIV_W-1]};
    rem_ge   = rem_sh >= {1'b0, divisor};
    rem_diff = rem_sh - {1'b0, divisor};
    rem_next = rem_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];

    // Integral update with the rounded increment and its sign.
    inc_ext = err[ERR_W-1] ? -$signed({{(INTEG_W-REM_W+1){1'b0}}, dq[REM_W-1:0]})
                           :  $signed({{(INTEG_W-REM_W+1){1'b0}}, dq[REM_W-1:0]});
    isum = {integ[INTEG_W-1], integ} + inc_ext;
    if (isum > stpc_pkg::INTEGRAL_LIMIT) begin
      integ_sat = INTEG_W'(stpc_pkg::INTEGRAL_LIMIT);
    end else if (isum < -stpc_pkg::INTEGRAL_LIMIT) begin
      integ_sat = INTEG_W'(-stpc_pkg::INTEGRAL_LIMIT);
    end else begin
      integ_sat = isum[INTEG_W-1:0];
    end

    // Turn numerator terms: error*(2^17 + 2^16) and integral*(2^6 + 2^5 + 2^2).
    case (cnt[2:0])
      3'd4:    term = {err, 17'b0};
      3'd3:    term = {err[ERR_W-1], err, 16'b0};
      3'd2:    term = {{7{integ[INTEG_W-1]}}, integ, 6'b0};
      3'd1:    term = {{8{integ[INTEG_W-1]}}, integ, 5'b0};
      3'd0:    term = {{11{integ[INTEG_W-1]}}, integ, 2'b0};
      default: term = '0;
    endcase

    // Magnitude plus half, folded into one add or subtract.
    tmag = tacc[TURN_W-1] ? (stpc_pkg::TURN_HALF - tacc) : (tacc + stpc_pkg::TURN_HALF);

    tq = (dq > {{(DIV_W-14){1'b0}}, stpc_pkg::TURN_LIMIT_MAG}) ?
         stpc_pkg::TURN_LIMIT_MAG : dq[13:0];

    // One multiplier bit per cycle, product shifting in from the top.
    mul_sum  = {1'b0, acc[ACC_W-1:MULB_W]} + {1'b0, (mul_b[0] ? mul_a : '0)};
    acc_step = {mul_sum, acc[MULB_W-1:1]};

    // Product / 2^30, rounded half away from zero on a magnitude.
    acc_round = acc[ACC_W-1:30] + {18'b0, acc[29]};
    drive_mag = (acc_round > {3'b0, stpc_pkg::DRIVE_LIMIT_MAG}) ?
                stpc_pkg::DRIVE_LIMIT_MAG : acc_round[15:0];
    drive_val = stick_neg ? -$signed(drive_mag) : $signed(drive_mag);
  end

  always_comb begin
    unique case (mul_op)
      stpc_pkg::OP_SQUARE: mul_op_next = stpc_pkg::OP_CUBE;
      stpc_pkg::OP_CUBE:   mul_op_next = stpc_pkg::OP_LINEAR;
      stpc_pkg::OP_LINEAR: mul_op_next = stpc_pkg::OP_CUBIC;
      default:             mul_op_next = stpc_pkg::OP_THROTTLE;
    endcase
  end

  assign in_ready = (state == stpc_pkg::S_IDLE);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_weight <= stpc_pkg::WEIGHT_RESET;
      cub_weight <= stpc_pkg::WEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        stpc_pkg::REG_LINEAR_WEIGHT: lin_weight <= cfg_data;
        stpc_pkg::REG_CUBIC_WEIGHT:  cub_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stpc_pkg::S_IDLE;
      mul_op    <= stpc_pkg::OP_SQUARE;
      cnt       <= '0;
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The finish state reloads the output register itself.
      if (out_valid && out_ready && (state != stpc_pkg::S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        stpc_pkg::S_IDLE: begin
          if (in_valid) begin
            err       <= err_sel;
            stick_mag <= stick_abs[15:0];
            stick_neg <= stick_y[15];
            thr       <= throttle_level;
            state     <= stpc_pkg::S_ZONE;
          end
        end

        // Pick the integral zone. The increment is (|e|*65536 + half) / divisor;
        // the half fits below the shifted error, so it is concatenated.
        stpc_pkg::S_ZONE: begin
          rem <= '0;
          if (err_mag < stpc_pkg::FINE_ZONE) begin
            dq      <= {err_mag[10:0], stpc_pkg::FINE_HALF};
            divisor <= stpc_pkg::FINE_DIVISOR;
            cnt     <= stpc_pkg::DIV_STEPS_LAST;
            state   <= stpc_pkg::S_DIV_INC;
          end else if (err_mag < stpc_pkg::COARSE_ZONE) begin
            dq      <= {err_mag[10:0], stpc_pkg::COARSE_HALF};
            divisor <= stpc_pkg::COARSE_DIVISOR;
            cnt     <= stpc_pkg::DIV_STEPS_LAST;
            state   <= stpc_pkg::S_DIV_INC;
          end else begin
            integ <= '0;
            tacc  <= '0;
            cnt   <= stpc_pkg::TURN_TERMS_LAST;
            state <= stpc_pkg::S_TURN_ADD;
          end
        end

        stpc_pkg::S_DIV_INC: begin
          rem <= rem_next;
          dq  <= {dq[DIV_W-2:0], rem_ge};
          if (cnt == '0) begin
            state <= stpc_pkg::S_INT_UPD;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end

        stpc_pkg::S_INT_UPD: begin
          integ <= integ_sat;
          tacc  <= '0;
          cnt   <= stpc_pkg::TURN_TERMS_LAST;
          state <= stpc_pkg::S_TURN_ADD;
        end

        // Build the turn numerator one shifted term per cycle.
        stpc_pkg::S_TURN_ADD: begin
          tacc <= tacc + term;
          if (cnt == '0) begin
            state <= stpc_pkg::S_TURN_LD;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end

        stpc_pkg::S_TURN_LD: begin
          tneg    <= tacc[TURN_W-1];
          dq      <= {{(DIV_W-TURN_W+9){1'b0}}, tmag[TURN_W-1:9]};
          rem     <= '0;
          divisor <= stpc_pkg::TURN_DIVISOR;
          cnt     <= stpc_pkg::DIV_STEPS_LAST;
          state   <= stpc_pkg::S_DIV_TURN;
        end

        stpc_pkg::S_DIV_TURN: begin
          rem <= rem_next;
          dq  <= {dq[DIV_W-2:0], rem_ge};
          if (cnt == '0) begin
            state <= stpc_pkg::S_TURN_SAT;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end

        stpc_pkg::S_TURN_SAT: begin
          turn_val <= tneg ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
          mul_op   <= stpc_pkg::OP_SQUARE;
          state    <= stpc_pkg::S_MUL_LD;
        end

        // Drive path on magnitudes: the cube and the mix share the stick's sign.
        stpc_pkg::S_MUL_LD: begin
          acc   <= '0;
          cnt   <= stpc_pkg::MUL_STEPS_LAST;
          state <= stpc_pkg::S_MUL_RUN;
          unique case (mul_op)
            stpc_pkg::OP_SQUARE: begin
              mul_a <= {{(MULA_W-16){1'b0}}, stick_mag};
              mul_b <= stick_mag;
            end
            stpc_pkg::OP_CUBE: begin
              mul_a <= {{(MULA_W-32){1'b0}}, acc[31:0]};
              mul_b <= stick_mag;
            end
            stpc_pkg::OP_LINEAR: begin
              cube_mag <= acc_round[15:0];
              mul_a    <= {{(MULA_W-16){1'b0}}, lin_weight};
              mul_b    <= stick_mag;
            end
            stpc_pkg::OP_CUBIC: begin
              mix_lin <= acc[31:0];
              mul_a   <= {{(MULA_W-16){1'b0}}, cub_weight};
              mul_b   <= cube_mag;
            end
            default: begin
              mul_a <= {1'b0, mix_lin} + {1'b0, acc[31:0]};
              mul_b <= thr;
            end
          endcase
        end

        stpc_pkg::S_MUL_RUN: begin
          acc   <= acc_step;
          mul_b <= mul_b >> 1;
          if (cnt == '0) begin
            if (mul_op == stpc_pkg::OP_THROTTLE) begin
              state <= stpc_pkg::S_FINISH;
            end else begin
              mul_op <= mul_op_next;
              state  <= stpc_pkg::S_MUL_LD;
            end
          end else begin
            cnt <= cnt - 5'd1;
          end
        end

        // Hand the result to the output register once it is free.
        stpc_pkg::S_FINISH: begin
          if (!out_valid || out_ready) begin
            drive_speed <= drive_val;
            turn_rate   <= turn_val;
            out_valid   <= 1'b1;
            state       <= stpc_pkg::S_IDLE;
          end
        end

        default: state <= stpc_pkg::S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `STPC_ASSERT(a_integ_range,
    (integ <= INTEG_W'(stpc_pkg::INTEGRAL_LIMIT)) &&
    (integ >= INTEG_W'(-stpc_pkg::INTEGRAL_LIMIT)),
    "integral left its clamp range")
  `STPC_ASSERT_IMPLY(a_turn_range, out_valid,
    (turn_rate <= $signed({1'b0, stpc_pkg::TURN_LIMIT_MAG})) &&
    (turn_rate >= -$signed({1'b0, stpc_pkg::TURN_LIMIT_MAG})),
    "turn command outside its saturation range")
  `STPC_ASSERT_IMPLY(a_drive_range, out_valid,
    drive_speed >= -$signed(stpc_pkg::DRIVE_LIMIT_MAG),
    "drive command below its saturation limit")
  `STPC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
    "new transaction accepted while one is in progress")

endmodule
